@@ sv/krt_pkg.sv @@
`default_nettype none

package krt_pkg;

	localparam int unsigned KEY_W   = 8;
	localparam int unsigned COUNT_W = 5;
	localparam logic [7:0]  GRADE_MAX = 8'd100;

	typedef enum logic [1:0] {
		ACT_ADD  = 2'd0,
		ACT_DEL  = 2'd1,
		ACT_READ = 2'd2,
		ACT_LIST = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] key;
		logic [7:0] year;
		logic [7:0] subject_a;
		logic [7:0] subject_b;
		logic [7:0] subject_c;
		logic [7:0] grade_a;
		logic [7:0] grade_b;
		logic [7:0] grade_c;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [7:0]         found_year;
		logic [7:0]         found_subject_a;
		logic [7:0]         found_subject_b;
		logic [7:0]         found_subject_c;
		logic [7:0]         found_grade_a;
		logic [7:0]         found_grade_b;
		logic [7:0]         found_grade_c;
		logic [7:0]         listed_key;
		logic [COUNT_W-1:0] used_count;
		logic               table_full;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [7:0] key;
		logic [7:0] year;
		logic [7:0] subject_a;
		logic [7:0] subject_b;
		logic [7:0] subject_c;
		logic [7:0] grade_a;
		logic [7:0] grade_b;
		logic [7:0] grade_c;
	} rec_t;

	// commands broadcast to every cell of the chain
	typedef struct packed {
		logic rotate;
		logic compact;
		logic load;
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ sv/keyed_record_table_compacting.sv @@
// Keyed record table with compaction.
// req channel (valid/ready): one operation item: add, delete, read by key or
// list keys. rsp channel (valid/ready): result items; add, delete and read give
// one, list gives one per stored key (last marks the final one, an empty
// table gives a single item with ok clear).
// Records sit in a ring of TABLE_DEPTH cells. Every operation rotates the ring
// one full turn past the head cell, where the key compare, the read capture and
// the list output happen; a delete then shifts the cells above the hit down
// all at once, an add loads the cell at the fill count.
// Add, delete and read present their result from the output register after the
// ring turn and the final step; a list presents its first key once the scan
// starts and the rest one per cycle while the receiver takes them. A new item
// is accepted only after the last one has left the final step; req_ready is
// high only between items. The ring turn sets the spacing of items.
// A list stalls its rotation while the receiver holds off rsp_ready; other
// items wait in the final step. A result is held in the output register until
// taken, and the next item may be accepted while the last result still waits.
// Reset empties the table (count cleared) and drops any pending result; record
// contents are not cleared.
`default_nettype none

module keyed_record_table_compacting #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire krt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output krt_pkg::rsp_t      rsp
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	krt_pkg::state_t    state_q, state_d;
	logic [IDX_W-1:0]   step_q;
	logic [CNT_W-1:0]   count_q;
	krt_pkg::req_t      req_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	krt_pkg::rec_t      found_q;
	logic               rsp_valid_q;
	krt_pkg::rsp_t      rsp_q;

	krt_pkg::rec_t      cell_rec [TABLE_DEPTH];
	krt_pkg::rec_t      head;
	krt_pkg::rec_t      load_rec;
	krt_pkg::cell_cmd_t cmd;
	logic [IDX_W-1:0]   slot;

	logic               req_fire;
	logic               out_free;
	logic               step_used;
	logic               step_last;
	logic               head_hit;
	logic               list_emit;
	logic               done_emit;
	logic               done_fire;
	logic               grade_ok;
	logic               add_good;
	logic [CNT_W-1:0]   count_nxt;
	logic               emit;
	krt_pkg::rsp_t      rsp_d;

	assign head      = cell_rec[0];
	assign req_ready = (state_q == krt_pkg::ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign step_used = (CNT_W'(step_q) < count_q);
	assign step_last = (step_q == IDX_W'(TABLE_DEPTH - 1));
	assign head_hit  = (state_q == krt_pkg::ST_SCAN) && step_used &&
		(req_q.key != '0) && (head.key == req_q.key);
	assign list_emit = (state_q == krt_pkg::ST_SCAN) &&
		(req_q.action == krt_pkg::ACT_LIST) && step_used;
	assign done_emit = (req_q.action != krt_pkg::ACT_LIST) || (count_q == '0);
	assign grade_ok  = (req_q.grade_a <= krt_pkg::GRADE_MAX) &&
		(req_q.grade_b <= krt_pkg::GRADE_MAX) && (req_q.grade_c <= krt_pkg::GRADE_MAX);
	assign add_good  = (count_q < CNT_W'(TABLE_DEPTH)) && (req_q.key != '0) &&
		!hit_q && grade_ok;

	assign load_rec = '{
		key:       req_q.key,
		year:      req_q.year,
		subject_a: req_q.subject_a,
		subject_b: req_q.subject_b,
		subject_c: req_q.subject_c,
		grade_a:   req_q.grade_a,
		grade_b:   req_q.grade_b,
		grade_c:   req_q.grade_c
	};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		krt_cell #(
			.IDX_W(IDX_W),
			.IDX  (i)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.slot    (slot),
			.load_rec(load_rec),
			.next_rec(cell_rec[(i + 1) % TABLE_DEPTH]),
			.rec     (cell_rec[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			krt_pkg::ST_IDLE: begin
				if (req_fire) state_d = krt_pkg::ST_SCAN;
			end
			krt_pkg::ST_SCAN: begin
				if (cmd.rotate && step_last) state_d = krt_pkg::ST_DONE;
			end
			krt_pkg::ST_DONE: begin
				if (done_fire) state_d = krt_pkg::ST_IDLE;
			end
			default: state_d = krt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		slot      = hit_idx_q;
		done_fire = 1'b0;
		count_nxt = count_q;
		unique case (state_q)
			krt_pkg::ST_SCAN: begin
				cmd.rotate = !list_emit || out_free;
			end
			krt_pkg::ST_DONE: begin
				done_fire = out_free || !done_emit;
				if (req_q.action == krt_pkg::ACT_ADD && add_good) begin
					count_nxt = count_q + CNT_W'(1);
					cmd.load  = done_fire;
					slot      = count_q[IDX_W-1:0];
				end else if (req_q.action == krt_pkg::ACT_DEL && hit_q) begin
					count_nxt   = count_q - CNT_W'(1);
					cmd.compact = done_fire;
				end
			end
			default: ;
		endcase
	end

	// result item
	always_comb begin
		rsp_d = '0;
		emit  = 1'b0;
		if (list_emit && cmd.rotate) begin
			emit             = 1'b1;
			rsp_d.ok         = 1'b1;
			rsp_d.listed_key = head.key;
			rsp_d.used_count = krt_pkg::COUNT_W'(count_q);
			rsp_d.table_full = (count_q == CNT_W'(TABLE_DEPTH));
			rsp_d.last       = (CNT_W'(step_q) == count_q - CNT_W'(1));
		end else if (done_fire && done_emit) begin
			emit             = 1'b1;
			rsp_d.used_count = krt_pkg::COUNT_W'(count_nxt);
			rsp_d.table_full = (count_nxt == CNT_W'(TABLE_DEPTH));
			rsp_d.last       = 1'b1;
			case (req_q.action)
				krt_pkg::ACT_ADD:  rsp_d.ok = add_good;
				krt_pkg::ACT_DEL:  rsp_d.ok = hit_q;
				krt_pkg::ACT_READ: begin
					rsp_d.ok = hit_q;
					if (hit_q) begin
						rsp_d.found_year      = found_q.year;
						rsp_d.found_subject_a = found_q.subject_a;
						rsp_d.found_subject_b = found_q.subject_b;
						rsp_d.found_subject_c = found_q.subject_c;
						rsp_d.found_grade_a   = found_q.grade_a;
						rsp_d.found_grade_b   = found_q.grade_b;
						rsp_d.found_grade_c   = found_q.grade_c;
					end
				end
				default: rsp_d.ok = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= krt_pkg::ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done_fire) count_q <= count_nxt;
			if (req_fire) begin
				step_q <= '0;
				hit_q  <= 1'b0;
			end else if (cmd.rotate) begin
				step_q <= step_last ? '0 : step_q + IDX_W'(1);
				if (head_hit) hit_q <= 1'b1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) req_q <= req;
		if (cmd.rotate && head_hit) begin
			hit_idx_q <= step_q;
			found_q   <= head;
		end
		if (emit) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ sv/krt_cell.sv @@
`default_nettype none

module krt_cell #(
	parameter int unsigned IDX_W = 4,
	parameter int unsigned IDX   = 0
) (
	input  wire logic              clk,
	input  wire krt_pkg::cell_cmd_t cmd,
	input  wire logic [IDX_W-1:0]  slot,
	input  wire krt_pkg::rec_t     load_rec,
	input  wire krt_pkg::rec_t     next_rec,
	output krt_pkg::rec_t          rec
);

	krt_pkg::rec_t rec_q;
	logic          is_slot;
	logic          at_or_above;

	assign is_slot     = (slot == IDX_W'(IDX));
	assign at_or_above = (IDX_W'(IDX) >= slot);
	assign rec         = rec_q;

	always_ff @(posedge clk) begin
		if (cmd.rotate) begin
			rec_q <= next_rec;
		end else if (cmd.compact && at_or_above) begin
			rec_q <= next_rec;
		end else if (cmd.load && is_slot) begin
			rec_q <= load_rec;
		end
	end

endmodule

`default_nettype wire

@@ sv/krt_checker.sv @@
`default_nettype none

module krt_checker #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire krt_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed before it was taken");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new item accepted while one is in work");

	a_run_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> !req_ready)
		else $error("item accepted before list run finished");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.table_full == (rsp.used_count == krt_pkg::COUNT_W'(TABLE_DEPTH))))
		else $error("full flag disagrees with used count");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> rsp.found_year == '0 && rsp.listed_key == '0)
		else $error("failed result carries data");

endmodule

bind keyed_record_table_compacting krt_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_krt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire
